### rtl/core/nfcs_pkg.sv
// ---------------------------------------------------------------------------
// nfcs_pkg: shared types and constants for the NOR flash command sequencer
// Field widths, opcodes, cycle kinds, flash command bytes and the job record
// that travels from the front end to the cycle generator.
// ---------------------------------------------------------------------------
package nfcs_pkg;

  // Field widths
  localparam int OPC_W      = 3;
  localparam int OFF_W      = 24;
  localparam int VAL_W      = 16;
  localparam int SEC_W      = 10;
  localparam int ADDR_W     = 32;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LOG2_W     = 5;
  localparam int CHK_W      = 25;

  // Used bits of the offset and sector fields
  localparam int ADDR_BITS   = 24;
  localparam int SECTOR_BITS = 10;

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_PROGRAM   = 3'd0;
  localparam logic [OPC_W-1:0] OP_ERASE_SEC = 3'd1;
  localparam logic [OPC_W-1:0] OP_ERASE_CHP = 3'd2;
  localparam logic [OPC_W-1:0] OP_READ_RET  = 3'd3;
  localparam logic [OPC_W-1:0] OP_WAIT_DONE = 3'd4;

  // Result cycle kinds
  localparam logic [KIND_W-1:0] K_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] K_READ  = 3'd1;
  localparam logic [KIND_W-1:0] K_WAIT  = 3'd2;
  localparam logic [KIND_W-1:0] K_OK    = 3'd3;
  localparam logic [KIND_W-1:0] K_ERR   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LOG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE = 3'd3;

  // Flash command addresses and data
  localparam logic [ADDR_W-1:0] UNLOCK1_ADDR  = 32'h0000_0AAA;
  localparam logic [ADDR_W-1:0] UNLOCK2_BYTE  = 32'h0000_0555;
  localparam logic [ADDR_W-1:0] UNLOCK2_WORD  = 32'h0000_0554;
  localparam logic [VAL_W-1:0]  CMD_UNLOCK1   = 16'h00AA;
  localparam logic [VAL_W-1:0]  CMD_UNLOCK2   = 16'h0055;
  localparam logic [VAL_W-1:0]  CMD_PROGRAM   = 16'h00A0;
  localparam logic [VAL_W-1:0]  CMD_ERASE     = 16'h0080;
  localparam logic [VAL_W-1:0]  CMD_SEC_ERASE = 16'h0030;
  localparam logic [VAL_W-1:0]  CMD_CHP_ERASE = 16'h0010;
  localparam logic [VAL_W-1:0]  CMD_RESET     = 16'h00F0;
  localparam logic [7:0]        ERASED_BYTE   = 8'hFF;
  localparam logic [VAL_W-1:0]  SEC_WAIT_MS   = 16'd3000;
  localparam logic [VAL_W-1:0]  CHP_WAIT_MS   = 16'd38000;
  localparam logic [7:0]        POLL_LIMIT    = 8'd150;

  // Saturation bounds of the size registers
  localparam logic [LOG2_W-1:0] SEC_LOG_MIN   = 5'd12;
  localparam logic [LOG2_W-1:0] SEC_LOG_MAX   = 5'd20;
  localparam logic [LOG2_W-1:0] FLASH_LOG_MIN = 5'd16;
  localparam logic [LOG2_W-1:0] FLASH_LOG_MAX = 5'd24;

  // Job types handed to the cycle generator
  localparam int JT_W = 3;
  localparam logic [JT_W-1:0] J_SINGLE = 3'd0;  // one result, fully given
  localparam logic [JT_W-1:0] J_PROG   = 3'd1;  // unlock, program, first poll
  localparam logic [JT_W-1:0] J_SERASE = 3'd2;  // unlock, sector erase, wait
  localparam logic [JT_W-1:0] J_CERASE = 3'd3;  // unlock, chip erase, wait
  localparam logic [JT_W-1:0] J_SWDONE = 3'd4;  // reset command, first check

  localparam int STEP_W = 3;

  // Job queue depth
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic              word_mode;
    logic [LOG2_W-1:0] sector_size_log2;
    logic [LOG2_W-1:0] flash_size_log2;
    logic [ADDR_W-1:0] flash_base;
  } cfg_t;

  typedef struct packed {
    logic [JT_W-1:0]   jtype;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic              wide;
  } job_t;

endpackage

### rtl/core/nfcs_intf.sv
// ---------------------------------------------------------------------------
// nfcs channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface nfcs_in_if import nfcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [OFF_W-1:0]   byte_offset;
  logic [VAL_W-1:0]   write_value;
  logic [SEC_W-1:0]   sector_number;
  logic [VAL_W-1:0]   bus_read_value;

  modport source (output valid, opcode, byte_offset, write_value, sector_number,
                  bus_read_value, input ready);
  modport sink   (input valid, opcode, byte_offset, write_value, sector_number,
                  bus_read_value, output ready);
endinterface

interface nfcs_out_if import nfcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  cycle_kind;
  logic [ADDR_W-1:0]  bus_address;
  logic [VAL_W-1:0]   bus_value;
  logic               wide_access;
  logic               last_of_run;

  modport source (output valid, cycle_kind, bus_address, bus_value, wide_access,
                  last_of_run, input ready);
  modport sink   (input valid, cycle_kind, bus_address, bus_value, wide_access,
                  last_of_run, output ready);
endinterface

interface nfcs_cfg_if import nfcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/nor_flash_command_sequencer.sv
// ---------------------------------------------------------------------------
// nor_flash_command_sequencer: NOR flash command sequencer, top level
// Turns program and erase requests into bus write, read and wait cycles.
// ---------------------------------------------------------------------------
// Channels: in_req carries requests and bus returns (read data, wait done);
// out_res carries the bus cycles to run and the done ok / done error status,
// with last_of_run on the final result of each request; cfg_wr writes the
// four setup registers and is always ready. Write configuration only while
// no request is in flight.
// Path: the first result of a request is written into the job queue on
// acceptance, then registered by the cycle generator, and is offered on
// out_res from then on.
// Throughput: the cycle generator emits one result per clock while out_res
// does not stall; a request has 7 results for an erase, 5 for a program,
// 2 for a sector wait done and 1 for a chip wait done, poll or check return.
// Requests are accepted every cycle while the four-entry job queue has room.
// Reset: phase idle, counters cleared, queue empty, registers at defaults.
// Stall: when out_res stalls, the result register holds; jobs back up in the
// queue and in_req.ready falls once the queue is full.
// ---------------------------------------------------------------------------
module nor_flash_command_sequencer import nfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nfcs_in_if.sink     in_req,
  nfcs_out_if.source  out_res,
  nfcs_cfg_if.sink    cfg_wr
);

  cfg_t cfg_r;
  job_t q_push_job, q_head_job;
  logic q_push, q_pop, q_head_valid, q_full;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_mode        <= 1'b0;
      cfg_r.sector_size_log2 <= 5'd16;
      cfg_r.flash_size_log2  <= 5'd21;
      cfg_r.flash_base       <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        CFG_WORD_MODE:  cfg_r.word_mode        <= cfg_wr.data[0];
        CFG_SECTOR_LOG: cfg_r.sector_size_log2 <= cfg_wr.data[LOG2_W-1:0];
        CFG_FLASH_LOG:  cfg_r.flash_size_log2  <= cfg_wr.data[LOG2_W-1:0];
        CFG_FLASH_BASE: cfg_r.flash_base       <= cfg_wr.data[ADDR_W-1:0];
        default:        cfg_r                  <= cfg_r;
      endcase
    end
  end

  nfcs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  nfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_job   (q_head_job),
    .head_valid (q_head_valid),
    .full       (q_full)
  );

  nfcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (q_head_job),
    .job_valid (q_head_valid),
    .job_pop   (q_pop),
    .out_res   (out_res)
  );

endmodule

### rtl/core/nfcs_front.sv
// ---------------------------------------------------------------------------
// nfcs_front: request front end
// Accepts requests and bus returns, tracks the operation phase, poll count
// and erase check position, and posts one job per request that has results.
// ---------------------------------------------------------------------------
module nfcs_front import nfcs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  nfcs_in_if.sink       in_req,
  input  logic          q_full,
  output logic          q_push,
  output job_t          q_job
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_POLL   = 3'd1;
  localparam logic [2:0] PH_SWAIT  = 3'd2;
  localparam logic [2:0] PH_SCHECK = 3'd3;
  localparam logic [2:0] PH_CWAIT  = 3'd4;
  localparam logic [2:0] PH_CCHECK = 3'd5;

  function automatic logic [LOG2_W-1:0] clamp5(input logic [LOG2_W-1:0] v,
                                               input logic [LOG2_W-1:0] lo,
                                               input logic [LOG2_W-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        poll_r, poll_nxt;
  logic [VAL_W-1:0]  exp_r, exp_nxt;
  logic [ADDR_W-1:0] tgt_r, tgt_nxt;
  logic [CHK_W-1:0]  idx_r, idx_nxt;
  logic [CHK_W-1:0]  end_r, end_nxt;

  logic                   accept;
  logic [VAL_W-1:0]       wr_masked, rd_masked;
  logic [7:0]             rd_byte;
  logic [ADDR_BITS-1:0]   off;
  logic [SECTOR_BITS-1:0] sec;
  logic [LOG2_W-1:0]      sl, fl;
  logic                   boot;
  logic [ADDR_W-1:0]      sec_start, sec_size;
  logic [CHK_W-1:0]       idx_inc;
  logic                   byte_ok, chk_done;
  logic [ADDR_W-1:0]      chk_addr;

  assign in_req.ready = !q_full;
  assign accept       = in_req.valid && in_req.ready;

  // Data masking by bus width
  assign wr_masked = cfg.word_mode ? in_req.write_value
                                   : {8'h00, in_req.write_value[7:0]};
  assign rd_masked = cfg.word_mode ? in_req.bus_read_value
                                   : {8'h00, in_req.bus_read_value[7:0]};
  assign rd_byte   = in_req.bus_read_value[7:0];

  // Sector geometry: eight boot sectors of one eighth size come first
  assign off  = in_req.byte_offset[ADDR_BITS-1:0];
  assign sec  = in_req.sector_number[SECTOR_BITS-1:0];
  assign sl   = clamp5(cfg.sector_size_log2, SEC_LOG_MIN, SEC_LOG_MAX);
  assign fl   = clamp5(cfg.flash_size_log2, FLASH_LOG_MIN, FLASH_LOG_MAX);
  assign boot = (sec < SECTOR_BITS'(8));
  assign sec_start = boot ? (ADDR_W'(sec) << (sl - LOG2_W'(3)))
                          : (ADDR_W'(sec - SECTOR_BITS'(7)) << sl);
  assign sec_size  = boot ? (ADDR_W'(1) << (sl - LOG2_W'(3)))
                          : (ADDR_W'(1) << sl);

  // Erase check step
  assign idx_inc  = idx_r + CHK_W'(1);
  assign byte_ok  = (rd_byte == ERASED_BYTE);
  assign chk_done = (idx_inc >= end_r);
  assign chk_addr = tgt_r + ADDR_W'(byte_ok ? idx_inc : idx_r);

  // Phase update and job build
  always_comb begin
    phase_nxt = phase_r;
    poll_nxt  = poll_r;
    exp_nxt   = exp_r;
    tgt_nxt   = tgt_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    q_push    = 1'b0;
    q_job     = '0;
    if (accept) begin
      priority if (in_req.opcode <= OP_ERASE_CHP && phase_r == PH_IDLE) begin
        q_push = 1'b1;
        unique case (in_req.opcode)
          OP_PROGRAM: begin
            exp_nxt   = wr_masked;
            tgt_nxt   = cfg.flash_base + ADDR_W'(off);
            poll_nxt  = 8'd1;
            phase_nxt = PH_POLL;
            q_job     = '{J_PROG, K_WRITE, tgt_nxt, wr_masked, cfg.word_mode};
          end
          OP_ERASE_SEC: begin
            tgt_nxt   = cfg.flash_base + sec_start;
            end_nxt   = CHK_W'(sec_size);
            idx_nxt   = '0;
            phase_nxt = PH_SWAIT;
            q_job     = '{J_SERASE, K_WRITE, tgt_nxt, '0, cfg.word_mode};
          end
          default: begin
            tgt_nxt   = cfg.flash_base;
            end_nxt   = CHK_W'(1) << fl;
            idx_nxt   = '0;
            phase_nxt = PH_CWAIT;
            q_job     = '{J_CERASE, K_WRITE, cfg.flash_base, '0, cfg.word_mode};
          end
        endcase
      end else if (in_req.opcode == OP_WAIT_DONE &&
                   (phase_r == PH_SWAIT || phase_r == PH_CWAIT)) begin
        q_push  = 1'b1;
        idx_nxt = '0;
        if (phase_r == PH_SWAIT) begin
          phase_nxt = PH_SCHECK;
          q_job     = '{J_SWDONE, K_READ, tgt_r, '0, cfg.word_mode};
        end else begin
          phase_nxt = PH_CCHECK;
          q_job     = '{J_SINGLE, K_READ, tgt_r, '0, 1'b0};
        end
      end else if (in_req.opcode == OP_READ_RET && phase_r == PH_POLL) begin
        q_push = 1'b1;
        priority if (rd_masked == exp_r) begin
          phase_nxt = PH_IDLE;
          q_job     = '{J_SINGLE, K_OK, tgt_r, '0, 1'b0};
        end else if (poll_r > POLL_LIMIT) begin
          phase_nxt = PH_IDLE;
          q_job     = '{J_SINGLE, K_ERR, tgt_r, rd_masked, 1'b0};
        end else begin
          poll_nxt = poll_r + 8'd1;
          q_job    = '{J_SINGLE, K_READ, tgt_r, '0, cfg.word_mode};
        end
      end else if (in_req.opcode == OP_READ_RET &&
                   (phase_r == PH_SCHECK || phase_r == PH_CCHECK)) begin
        q_push = 1'b1;
        priority if (!byte_ok) begin
          phase_nxt = PH_IDLE;
          q_job     = '{J_SINGLE, K_ERR, chk_addr, {8'h00, rd_byte}, 1'b0};
        end else if (chk_done) begin
          idx_nxt   = idx_inc;
          phase_nxt = PH_IDLE;
          q_job     = '{J_SINGLE, K_OK, tgt_r, '0, 1'b0};
        end else begin
          idx_nxt = idx_inc;
          q_job   = '{J_SINGLE, K_READ, chk_addr, '0, 1'b0};
        end
      end else begin
        // busy, unexpected or unknown request: consumed without results
        q_push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      poll_r  <= '0;
      exp_r   <= '0;
      tgt_r   <= '0;
      idx_r   <= '0;
      end_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      poll_r  <= poll_nxt;
      exp_r   <= exp_nxt;
      tgt_r   <= tgt_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

### rtl/core/nfcs_queue.sv
// ---------------------------------------------------------------------------
// nfcs_queue: job queue
// Small FIFO between the front end and the cycle generator.
// ---------------------------------------------------------------------------
module nfcs_queue import nfcs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_job,
  input  logic  pop,
  output job_t  head_job,
  output logic  head_valid,
  output logic  full
);

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (Q_PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (Q_PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/nfcs_back.sv
// ---------------------------------------------------------------------------
// nfcs_back: bus cycle generator
// Expands the job at the queue head into its bus cycles, one per clock while
// out_res does not stall, into a registered result stage.
// ---------------------------------------------------------------------------
module nfcs_back import nfcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_pop,
  nfcs_out_if.source out_res
);

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r, kind_c;
  logic [ADDR_W-1:0] addr_r, addr_c;
  logic [VAL_W-1:0]  value_r, value_c;
  logic              wide_r, wide_c;
  logic              last_r, last_c;
  logic              advance;
  logic [ADDR_W-1:0] a_unl1, a_unl2;
  logic              is_prog, is_serase;

  assign a_unl1    = cfg.flash_base + UNLOCK1_ADDR;
  assign a_unl2    = cfg.flash_base + (cfg.word_mode ? UNLOCK2_WORD : UNLOCK2_BYTE);
  assign is_prog   = (job.jtype == J_PROG);
  assign is_serase = (job.jtype == J_SERASE);

  // Cycle for the current step of the head job
  always_comb begin
    kind_c  = K_WRITE;
    addr_c  = a_unl1;
    value_c = CMD_UNLOCK1;
    wide_c  = job.wide;
    last_c  = 1'b0;
    unique case (job.jtype)
      J_SINGLE: begin
        kind_c  = job.kind;
        addr_c  = job.addr;
        value_c = job.value;
        last_c  = 1'b1;
      end
      J_SWDONE: begin
        if (step_r == STEP_W'(0)) begin
          addr_c  = cfg.flash_base;
          value_c = CMD_RESET;
        end else begin
          kind_c  = K_READ;
          addr_c  = job.addr;
          value_c = '0;
          wide_c  = 1'b0;
          last_c  = 1'b1;
        end
      end
      default: begin
        // command sequences: program or erase
        unique case (step_r)
          3'd0: begin
            addr_c  = a_unl1;
            value_c = CMD_UNLOCK1;
          end
          3'd1: begin
            addr_c  = a_unl2;
            value_c = CMD_UNLOCK2;
          end
          3'd2: begin
            addr_c  = a_unl1;
            value_c = is_prog ? CMD_PROGRAM : CMD_ERASE;
          end
          3'd3: begin
            addr_c  = is_prog ? job.addr : a_unl1;
            value_c = is_prog ? job.value : CMD_UNLOCK1;
          end
          3'd4: begin
            if (is_prog) begin
              kind_c  = K_READ;
              addr_c  = job.addr;
              value_c = '0;
              last_c  = 1'b1;
            end else begin
              addr_c  = a_unl2;
              value_c = CMD_UNLOCK2;
            end
          end
          3'd5: begin
            addr_c  = is_serase ? job.addr : a_unl1;
            value_c = is_serase ? CMD_SEC_ERASE : CMD_CHP_ERASE;
          end
          default: begin
            kind_c  = K_WAIT;
            addr_c  = job.addr;
            value_c = is_serase ? SEC_WAIT_MS : CHP_WAIT_MS;
            wide_c  = 1'b0;
            last_c  = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign advance = job_valid && (!out_valid_r || out_res.ready);
  assign job_pop = advance && last_c;

  // Step counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      step_r      <= last_c ? '0 : step_r + STEP_W'(1);
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r  <= kind_c;
      addr_r  <= addr_c;
      value_r <= value_c;
      wide_r  <= wide_c;
      last_r  <= last_c;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.cycle_kind  = kind_r;
  assign out_res.bus_address = addr_r;
  assign out_res.bus_value   = value_r;
  assign out_res.wide_access = wide_r;
  assign out_res.last_of_run = last_r;

endmodule

### verif/nor_flash_command_sequencer_tb.sv
// ---------------------------------------------------------------------------
// nor_flash_command_sequencer_tb: self-checking testbench for the sequencer
// Drives program, sector erase and chip erase requests together with the
// bus returns they call for (poll reads, wait done, erase check reads),
// predicts every bus cycle and status result in a scoreboard and checks the
// result channel in order. Random idle and stall on both channels, several
// register settings including the saturating extremes.
// ---------------------------------------------------------------------------
import nfcs_pkg::*;

// Sequencer phases as tracked by the predictor
typedef enum logic [3:0] {
  SEQ_IDLE, SEQ_POLL, SEQ_SWAIT, SEQ_SCHECK, SEQ_CWAIT, SEQ_CCHECK
} seq_phase_t;

typedef struct {
  logic [OPC_W-1:0] opcode;
  logic [OFF_W-1:0] byte_offset;
  logic [VAL_W-1:0] write_value;
  logic [SEC_W-1:0] sector_number;
  logic [VAL_W-1:0] bus_read_value;
} flash_req_t;

typedef struct {
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] addr;
  logic [VAL_W-1:0]  value;
  logic              wide;
  logic              last_of_run;
} bus_cycle_t;

// Predicts the sequencer and holds the bus cycles still owed by the block
class nfcs_scoreboard;
  localparam int BOOT_SECTORS = 8;

  logic              word_mode;
  logic [LOG2_W-1:0] sector_log;
  logic [LOG2_W-1:0] flash_log;
  logic [ADDR_W-1:0] flash_base;

  seq_phase_t        phase;
  logic [7:0]        poll_count;
  logic [VAL_W-1:0]  expected_value;
  logic [ADDR_W-1:0] target_address;
  logic [CHK_W-1:0]  check_index;
  logic [CHK_W-1:0]  check_end;

  bus_cycle_t        cycle_q[$];
  bus_cycle_t        run_q[$];
  int                mismatches;

  function new();
    word_mode      = 1'b0;
    sector_log     = 5'd16;
    flash_log      = 5'd21;
    flash_base     = '0;
    phase          = SEQ_IDLE;
    poll_count     = '0;
    expected_value = '0;
    target_address = '0;
    check_index    = '0;
    check_end      = '0;
    mismatches     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_WORD_MODE:  word_mode  = data[0];
      CFG_SECTOR_LOG: sector_log = data[LOG2_W-1:0];
      CFG_FLASH_LOG:  flash_log  = data[LOG2_W-1:0];
      CFG_FLASH_BASE: flash_base = data;
      default: ;
    endcase
  endfunction

  function logic [LOG2_W-1:0] sat(logic [LOG2_W-1:0] v, logic [LOG2_W-1:0] lo,
                                  logic [LOG2_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function void emit(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                     logic [VAL_W-1:0] value, logic wide);
    bus_cycle_t c;
    c.kind        = kind;
    c.addr        = addr;
    c.value       = value;
    c.wide        = wide;
    c.last_of_run = 1'b0;
    run_q.push_back(c);
  endfunction

  // Unlock, erase setup, unlock: common head of both erase commands
  function void emit_erase_unlock(logic [ADDR_W-1:0] unlock2);
    emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_UNLOCK1, word_mode);
    emit(K_WRITE, unlock2, CMD_UNLOCK2, word_mode);
    emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_ERASE, word_mode);
    emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_UNLOCK1, word_mode);
    emit(K_WRITE, unlock2, CMD_UNLOCK2, word_mode);
  endfunction

  // Accepted request or bus return: advance the state, queue its results
  function void note_request(flash_req_t r);
    logic [VAL_W-1:0]  dmask;
    logic [VAL_W-1:0]  rv;
    logic [ADDR_W-1:0] unlock2;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] sec;
    logic [ADDR_W-1:0] big;
    logic [ADDR_W-1:0] sec_bytes;
    logic [ADDR_W-1:0] sec_start;
    run_q.delete();
    dmask   = word_mode ? 16'hFFFF : 16'h00FF;
    unlock2 = flash_base + (word_mode ? UNLOCK2_WORD : UNLOCK2_BYTE);

    if (r.opcode <= OP_ERASE_CHP && phase == SEQ_IDLE) begin
      if (r.opcode == OP_PROGRAM) begin
        off = ADDR_W'(r.byte_offset) & ((ADDR_W'(1) << ADDR_BITS) - 1);
        expected_value = r.write_value & dmask;
        target_address = flash_base + off;
        emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_UNLOCK1, word_mode);
        emit(K_WRITE, unlock2, CMD_UNLOCK2, word_mode);
        emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_PROGRAM, word_mode);
        emit(K_WRITE, target_address, expected_value, word_mode);
        emit(K_READ, target_address, '0, word_mode);
        poll_count = 8'd1;
        phase      = SEQ_POLL;
      end else if (r.opcode == OP_ERASE_SEC) begin
        sec       = ADDR_W'(r.sector_number) & ((ADDR_W'(1) << SECTOR_BITS) - 1);
        big       = ADDR_W'(1) << sat(sector_log, SEC_LOG_MIN, SEC_LOG_MAX);
        sec_bytes = (sec < BOOT_SECTORS) ? (big >> 3) : big;
        sec_start = (sec < BOOT_SECTORS) ? sec_bytes * sec : big * (sec - 7);
        target_address = flash_base + sec_start;
        check_end      = CHK_W'(sec_bytes);
        check_index    = '0;
        emit_erase_unlock(unlock2);
        emit(K_WRITE, target_address, CMD_SEC_ERASE, word_mode);
        emit(K_WAIT, target_address, SEC_WAIT_MS, 1'b0);
        phase = SEQ_SWAIT;
      end else begin
        target_address = flash_base;
        check_end      = CHK_W'(1) << sat(flash_log, FLASH_LOG_MIN, FLASH_LOG_MAX);
        check_index    = '0;
        emit_erase_unlock(unlock2);
        emit(K_WRITE, flash_base + UNLOCK1_ADDR, CMD_CHP_ERASE, word_mode);
        emit(K_WAIT, target_address, CHP_WAIT_MS, 1'b0);
        phase = SEQ_CWAIT;
      end
    end else if (r.opcode == OP_WAIT_DONE && (phase == SEQ_SWAIT || phase == SEQ_CWAIT)) begin
      // sector erase needs the reset command before reading back
      if (phase == SEQ_SWAIT) begin
        emit(K_WRITE, flash_base, CMD_RESET, word_mode);
        phase = SEQ_SCHECK;
      end else begin
        phase = SEQ_CCHECK;
      end
      check_index = '0;
      emit(K_READ, target_address, '0, 1'b0);
    end else if (r.opcode == OP_READ_RET && phase == SEQ_POLL) begin
      rv = r.bus_read_value & dmask;
      if (rv == expected_value) begin
        emit(K_OK, target_address, '0, 1'b0);
        phase = SEQ_IDLE;
      end else if (poll_count > POLL_LIMIT) begin
        emit(K_ERR, target_address, rv, 1'b0);
        phase = SEQ_IDLE;
      end else begin
        poll_count = poll_count + 8'd1;
        emit(K_READ, target_address, '0, word_mode);
      end
    end else if (r.opcode == OP_READ_RET && (phase == SEQ_SCHECK || phase == SEQ_CCHECK)) begin
      // erase check looks at the low byte only
      if (r.bus_read_value[7:0] != ERASED_BYTE) begin
        emit(K_ERR, target_address + ADDR_W'(check_index),
             {8'h00, r.bus_read_value[7:0]}, 1'b0);
        phase = SEQ_IDLE;
      end else begin
        check_index = check_index + 1'b1;
        if (check_index >= check_end) begin
          emit(K_OK, target_address, '0, 1'b0);
          phase = SEQ_IDLE;
        end else begin
          emit(K_READ, target_address + ADDR_W'(check_index), '0, 1'b0);
        end
      end
    end

    if (run_q.size() > 0) begin
      run_q[run_q.size()-1].last_of_run = 1'b1;
      foreach (run_q[i]) cycle_q.push_back(run_q[i]);
    end
  endfunction

  // Compare one accepted result with the oldest owed cycle
  function void check_result(bus_cycle_t got);
    bus_cycle_t exp_c;
    if (cycle_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind=%0d addr=%h value=%h wide=%0d last=%0d",
                 got.kind, got.addr, got.value, got.wide, got.last_of_run);
      return;
    end
    exp_c = cycle_q.pop_front();
    if (got.kind !== exp_c.kind || got.addr !== exp_c.addr || got.value !== exp_c.value ||
        got.wide !== exp_c.wide || got.last_of_run !== exp_c.last_of_run) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp kind=%0d addr=%h value=%h wide=%0d last=%0d / got kind=%0d addr=%h value=%h wide=%0d last=%0d",
                 exp_c.kind, exp_c.addr, exp_c.value, exp_c.wide, exp_c.last_of_run,
                 got.kind, got.addr, got.value, got.wide, got.last_of_run);
    end
  endfunction
endclass

module nor_flash_command_sequencer_tb;
  localparam int TIMEOUT        = 20_000_000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int CHECK_ALL      = -1;
  localparam int FAIL_PICK      = -2;
  localparam int FULL_CHECK_MAX = 512;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic clk;
  logic rst_n;

  nfcs_in_if  in_req ();
  nfcs_out_if out_res ();
  nfcs_cfg_if cfg_wr ();

  nor_flash_command_sequencer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  nfcs_scoreboard sb = new();

  bit no_idle          = 1'b0;
  int work_items       = 0;
  int poll_misses_left = 0;
  int fail_at          = CHECK_ALL;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(TIMEOUT);
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: check accepted results, then pick next ready
  initial begin
    bus_cycle_t got;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
        got.kind        = out_res.cycle_kind;
        got.addr        = out_res.bus_address;
        got.value       = out_res.bus_value;
        got.wide        = out_res.wide_access;
        got.last_of_run = out_res.last_of_run;
        sb.check_result(got);
      end
      out_res.ready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  function automatic flash_req_t rand_req(logic [OPC_W-1:0] op);
    flash_req_t r;
    r.opcode         = op;
    r.byte_offset    = OFF_W'($urandom);
    r.write_value    = VAL_W'($urandom);
    r.sector_number  = SEC_W'($urandom);
    r.bus_read_value = VAL_W'($urandom);
    return r;
  endfunction

  function automatic bit is_ignored(logic [OPC_W-1:0] op, seq_phase_t ph);
    if (op > OP_WAIT_DONE) return 1'b1;
    if (op <= OP_ERASE_CHP) return ph != SEQ_IDLE;
    if (op == OP_WAIT_DONE) return !(ph == SEQ_SWAIT || ph == SEQ_CWAIT);
    return !(ph == SEQ_POLL || ph == SEQ_SCHECK || ph == SEQ_CCHECK);
  endfunction

  // Random request that the current phase must drop
  function automatic flash_req_t noise_req();
    logic [OPC_W-1:0] op;
    do op = OPC_W'($urandom); while (!is_ignored(op, sb.phase));
    return rand_req(op);
  endfunction

  // Poll read data, random above the compared width
  function automatic logic [VAL_W-1:0] poll_value(bit hit);
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] v;
    mask = sb.word_mode ? 16'hFFFF : 16'h00FF;
    v    = VAL_W'($urandom) & ~mask;
    if (hit) return v | sb.expected_value;
    return v | ((sb.expected_value ^ VAL_W'($urandom_range(1, int'(mask)))) & mask);
  endfunction

  function automatic int pick_fail_at();
    int span;
    span = int'(sb.check_end);
    if (span <= FULL_CHECK_MAX && $urandom_range(99) < 10) return CHECK_ALL;
    if (span <= FULL_CHECK_MAX && $urandom_range(99) < 10) return span - 1;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return OFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [SEC_W-1:0] rand_sector();
    case ($urandom_range(9))
      0, 1, 2, 3: return SEC_W'($urandom_range(0, 7));
      4:          return SEC_W'(8);
      5:          return '1;
      default:    return SEC_W'($urandom);
    endcase
  endfunction

  // One request on in_req; payload holds until the request is accepted
  task automatic send_req(input flash_req_t r, input bit counted);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.opcode         <= r.opcode;
    in_req.byte_offset    <= r.byte_offset;
    in_req.write_value    <= r.write_value;
    in_req.sector_number  <= r.sector_number;
    in_req.bus_read_value <= r.bus_read_value;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    sb.note_request(r);
    if (counted) work_items++;
  endtask

  task automatic drop_req();
    in_req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Answer the sequencer until it is back to idle, with some noise mixed in
  task automatic serve_run();
    flash_req_t r;
    while (sb.phase != SEQ_IDLE) begin
      if ($urandom_range(99) < 8) begin
        send_req(noise_req(), 1'b0);
      end else begin
        case (sb.phase)
          SEQ_POLL: begin
            r = rand_req(OP_READ_RET);
            r.bus_read_value = poll_value(poll_misses_left == 0);
            if (poll_misses_left > 0) poll_misses_left--;
          end
          SEQ_SWAIT, SEQ_CWAIT: begin
            r = rand_req(OP_WAIT_DONE);
          end
          default: begin
            r = rand_req(OP_READ_RET);
            r.bus_read_value[7:0] = (int'(sb.check_index) == fail_at) ?
                                    8'($urandom_range(0, 254)) : ERASED_BYTE;
          end
        endcase
        send_req(r, 1'b1);
      end
    end
  endtask

  // Program; misses = poll reads that return wrong data first
  task automatic program_run(input logic [OFF_W-1:0] off, input logic [VAL_W-1:0] val,
                             input int misses, input bit poke);
    flash_req_t r;
    r = rand_req(OP_PROGRAM);
    r.byte_offset    = off;
    r.write_value    = val;
    poll_misses_left = misses;
    send_req(r, 1'b1);
    if (poke) begin
      // busy request and a wait done that nobody waits for
      send_req(rand_req(OP_ERASE_CHP), 1'b0);
      send_req(rand_req(OP_WAIT_DONE), 1'b0);
    end
    serve_run();
  endtask

  task automatic erase_run(input logic [OPC_W-1:0] op, input logic [SEC_W-1:0] sec,
                           input int fail_pos, input bit poke);
    flash_req_t r;
    r = rand_req(op);
    r.sector_number = sec;
    send_req(r, 1'b1);
    fail_at = (fail_pos == FAIL_PICK) ? pick_fail_at() : fail_pos;
    if (poke) begin
      // read return during the wait and a busy program
      send_req(rand_req(OP_READ_RET), 1'b0);
      send_req(rand_req(OP_PROGRAM), 1'b0);
    end
    serve_run();
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    int pick;
    int misses;
    stop_at = work_items + budget;
    while (work_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_req(noise_req(), 1'b0);
      end else if (pick < 55) begin
        misses = $urandom_range(0, 3);
        program_run(rand_offset(), VAL_W'($urandom), misses, 1'b0);
      end else if (pick < 88) begin
        erase_run(OP_ERASE_SEC, rand_sector(), FAIL_PICK, 1'b0);
      end else begin
        erase_run(OP_ERASE_CHP, SEC_W'($urandom), FAIL_PICK, 1'b0);
      end
    end
    drop_req();
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    @(posedge clk);
    while (cfg_wr.ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the block to drain, then let ignored requests retire
  task automatic settle();
    while (sb.cycle_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic wm, input logic [LOG2_W-1:0] sec_log,
                           input logic [LOG2_W-1:0] fl_log, input logic [ADDR_W-1:0] base);
    settle();
    cfg_write(CFG_WORD_MODE, ($urandom & ~32'h1) | CFG_DATA_W'(wm));
    cfg_write(CFG_SECTOR_LOG, ($urandom & ~32'h1F) | CFG_DATA_W'(sec_log));
    cfg_write(CFG_FLASH_LOG, ($urandom & ~32'h1F) | CFG_DATA_W'(fl_log));
    cfg_write(CFG_FLASH_BASE, base);
  endtask

  // Main sequence
  initial begin
    rst_n                 <= 1'b0;
    in_req.valid          <= 1'b0;
    in_req.opcode         <= '0;
    in_req.byte_offset    <= '0;
    in_req.write_value    <= '0;
    in_req.sector_number  <= '0;
    in_req.bus_read_value <= '0;
    cfg_wr.valid          <= 1'b0;
    cfg_wr.index          <= '0;
    cfg_wr.data           <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values
    for (int op = OP_READ_RET; op < 8; op++) send_req(rand_req(OPC_W'(op)), 1'b0);
    program_run('0, '0, 0, 1'b1);
    program_run('1, '1, 2, 1'b0);
    program_run(rand_offset(), VAL_W'($urandom), 151, 1'b0);
    program_run(rand_offset(), VAL_W'($urandom), 150, 1'b0);
    erase_run(OP_ERASE_SEC, SEC_W'(0), 0, 1'b1);
    erase_run(OP_ERASE_SEC, SEC_W'(7), 3, 1'b0);
    erase_run(OP_ERASE_SEC, SEC_W'(8), 1, 1'b0);
    erase_run(OP_ERASE_SEC, '1, 0, 1'b0);
    erase_run(OP_ERASE_CHP, '0, 2, 1'b1);
    drop_req();

    // Word mode, smallest sizes, base near the top of the address space
    configure(1'b1, 5'd12, 5'd16, 32'hFFFF_F000);
    random_phase(30);

    // Byte mode, largest sizes, no idle on either side
    no_idle = 1'b1;
    configure(1'b0, 5'd20, 5'd24, $urandom);
    random_phase(30);
    no_idle = 1'b0;

    // Below and above range: saturate to the smallest sector, largest flash
    configure(1'b1, 5'd0, 5'd31, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE, $urandom);
    random_phase(30);

    // Largest sector, smallest flash
    configure(1'b0, 5'd31, 5'd0, '0);
    erase_run(OP_ERASE_CHP, '0, FAIL_PICK, 1'b0);
    random_phase(30);

    configure(1'($urandom), LOG2_W'($urandom), LOG2_W'($urandom), $urandom);
    random_phase(30);

    // Drain and finish
    while (sb.cycle_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.cycle_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/nfcs_pkg.sv
rtl/core/nfcs_intf.sv
rtl/core/nfcs_front.sv
rtl/core/nfcs_queue.sv
rtl/core/nfcs_back.sv
rtl/core/nor_flash_command_sequencer.sv
verif/nor_flash_command_sequencer_tb.sv
